// File: hw/rtl/jec_pkg.sv
// Package for the joystick event conditioner: sizes, configuration layout,
// command and state types shared by the front, queue and back modules.
// No dependencies.
package jec_pkg;

  localparam int NUM_AXES    = 8;
  localparam int NUM_BUTTONS = 16;
  localparam int NUM_ENTRIES = NUM_AXES + NUM_BUTTONS;

  localparam int AXIS_IDX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int ENTRY_W     = $clog2(NUM_ENTRIES);

  // Mask registers have fixed widths; channels beyond them are never masked.
  localparam int AXIS_MASK_W = 8;
  localparam int BTN_MASK_W  = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE_LEVEL     = 3'd0,
    REG_DEADZONE_GAIN      = 3'd1,
    REG_AXIS_REVERSE_MASK  = 3'd2,
    REG_BUTTON_INVERT_MASK = 3'd3,
    REG_STICKY_MODE        = 3'd4,
    REG_PUBLISH_INTERVAL   = 3'd5,
    REG_COALESCE_WINDOW    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [14:0] deadzone_level;
    logic [19:0] deadzone_gain;
    logic [7:0]  axis_reverse_mask;
    logic [15:0] button_invert_mask;
    logic        sticky_mode;
    logic [31:0] publish_interval;
    logic [31:0] coalesce_window;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    deadzone_level:     15'd0,
    deadzone_gain:      20'd32768,
    axis_reverse_mask:  8'd0,
    button_invert_mask: 16'd0,
    sticky_mode:        1'b0,
    publish_interval:   32'd10000,
    coalesce_window:    32'd0
  };

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_AXIS   = 2'd1,
    CMD_BUTTON = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               idx_ok;
    logic               mark;
    logic [7:0]         idx;
    logic signed [15:0] sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_APPLY,
    ST_DECIDE,
    ST_REPORT
  } back_state_t;

endpackage

// File: hw/rtl/jec_front.sv
// Front end of the joystick event conditioner: accepts input transactions,
// classifies them into commands and hands them to the command queue.
// Depends on jec_pkg.
module jec_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic                in_event_kind,
  input  logic                in_init_flag,
  input  logic [7:0]          in_channel_index,
  input  logic signed [15:0]  in_sample_value,
  input  jec_pkg::q_stat_t    q_stat,
  output logic                q_push,
  output jec_pkg::cmd_t       q_cmd
);

  logic          hold_valid_r, hold_valid_nxt;
  jec_pkg::cmd_t hold_cmd_r, hold_cmd_nxt;
  jec_pkg::cmd_t cls;
  logic          accept;

  // Axis events always mark the store dirty; button events only when they
  // are not initial-state reports from the device.
  always_comb begin
    cls.idx    = in_channel_index;
    cls.sample = in_sample_value;
    if (in_op) begin
      cls.kind   = jec_pkg::CMD_TICK;
      cls.idx_ok = 1'b0;
      cls.mark   = 1'b0;
    end else if (in_event_kind) begin
      cls.kind   = jec_pkg::CMD_AXIS;
      cls.idx_ok = in_channel_index < 8'(jec_pkg::NUM_AXES);
      cls.mark   = 1'b1;
    end else begin
      cls.kind   = jec_pkg::CMD_BUTTON;
      cls.idx_ok = in_channel_index < 8'(jec_pkg::NUM_BUTTONS);
      cls.mark   = !in_init_flag;
    end
  end

  assign q_push   = hold_valid_r && !q_stat.full;
  assign in_ready = !hold_valid_r || q_push;
  assign accept   = in_valid && in_ready;
  assign q_cmd    = hold_cmd_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_cmd_nxt   = hold_cmd_r;
    if (q_push) begin
      hold_valid_nxt = 1'b0;
    end
    if (accept) begin
      hold_valid_nxt = 1'b1;
      hold_cmd_nxt   = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_cmd_r <= hold_cmd_nxt;
  end

endmodule

// File: hw/rtl/jec_queue.sv
// Short command queue between the front and back of the conditioner.
// Depends on jec_pkg.
module jec_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jec_pkg::cmd_t    cmd_in,
  input  logic             pop,
  output jec_pkg::cmd_t    cmd_out,
  output jec_pkg::q_stat_t stat
);

  jec_pkg::cmd_t                entries_r [jec_pkg::QUEUE_DEPTH];
  logic [jec_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [jec_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [jec_pkg::QCNT_W-1:0]   count_r, count_nxt;

  localparam logic [jec_pkg::QPTR_W-1:0] LAST_PTR = jec_pkg::QPTR_W'(jec_pkg::QUEUE_DEPTH - 1);

  assign stat.full  = count_r == jec_pkg::QCNT_W'(jec_pkg::QUEUE_DEPTH);
  assign stat.empty = count_r == '0;
  assign cmd_out    = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      entries_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// File: hw/rtl/jec_back.sv
// Back end of the conditioner: executes queued commands on the channel store
// and tick counters, decides on reports and walks the store into the output.
// Depends on jec_pkg.
module jec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jec_pkg::cfg_t       cfg,
  input  jec_pkg::q_stat_t    q_stat,
  input  jec_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_channel_kind,
  output logic [3:0]          out_channel_number,
  output logic signed [15:0]  out_channel_value,
  output logic [47:0]         out_report_time,
  output logic                out_last_entry
);

  localparam int NA = jec_pkg::NUM_AXES;
  localparam int NB = jec_pkg::NUM_BUTTONS;
  localparam int EW = jec_pkg::ENTRY_W;

  jec_pkg::back_state_t state_r, state_nxt;
  jec_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [35:0]          prod_r, prod_nxt;
  logic                 dead_r, dead_nxt;
  logic [EW-1:0]        walk_r, walk_nxt;

  logic signed [15:0]   axis_store_r [NA];
  logic signed [15:0]   axis_store_nxt [NA];
  logic                 btn_store_r [NB];
  logic                 btn_store_nxt [NB];
  logic                 dirty_r, dirty_nxt;
  logic [31:0]          tsc_r, tsc_nxt;
  logic [31:0]          tsr_r, tsr_nxt;
  logic [47:0]          tick_r, tick_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [3:0]           out_num_r, out_num_nxt;
  logic signed [15:0]   out_val_r, out_val_nxt;
  logic [47:0]          out_time_r, out_time_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [15:0]          mag;
  logic [15:0]          dz16;
  logic [15:0]          diff;
  logic [36:0]          rounded;
  logic [21:0]          scaled;
  logic [14:0]          sat;
  logic                 rev;
  logic signed [15:0]   axis_val;
  logic                 inv;
  logic signed [16:0]   btn_v;
  logic                 report;
  logic [EW-1:0]        btn_walk;
  logic                 load_ok;

  // Magnitude of the sample; the most negative code maps to 32768.
  always_comb begin
    mag  = cmd_r.sample[15] ? (~cmd_r.sample + 16'd1) : cmd_r.sample;
    dz16 = {1'b0, cfg.deadzone_level};
    diff = mag - dz16;
  end

  // Rounding, saturation and sign handling after the registered product.
  always_comb begin
    rounded  = {1'b0, prod_r} + 37'd16384;
    scaled   = rounded[36:15];
    sat      = (scaled > 22'd32767) ? 15'h7fff : scaled[14:0];
    rev      = (cmd_r.idx < 8'(jec_pkg::AXIS_MASK_W)) &&
               cfg.axis_reverse_mask[cmd_r.idx[2:0]];
    if (dead_r) begin
      axis_val = '0;
    end else if (cmd_r.sample[15] ^ rev) begin
      axis_val = -$signed({1'b0, sat});
    end else begin
      axis_val = $signed({1'b0, sat});
    end
    inv   = (cmd_r.idx < 8'(jec_pkg::BTN_MASK_W)) &&
            cfg.button_invert_mask[cmd_r.idx[3:0]];
    btn_v = inv ? (17'sd1 - 17'(cmd_r.sample)) : 17'(cmd_r.sample);
  end

  assign report = (dirty_r && (cfg.coalesce_window != '0)) ?
                  (tsc_r >= cfg.coalesce_window) :
                  (tsr_r >= cfg.publish_interval);

  assign btn_walk = walk_r - EW'(NA);
  assign load_ok  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    prod_nxt       = prod_r;
    dead_nxt       = dead_r;
    walk_nxt       = walk_r;
    axis_store_nxt = axis_store_r;
    btn_store_nxt  = btn_store_r;
    dirty_nxt      = dirty_r;
    tsc_nxt        = tsc_r;
    tsr_nxt        = tsr_r;
    tick_nxt       = tick_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_num_nxt    = out_num_r;
    out_val_nxt    = out_val_r;
    out_time_nxt   = out_time_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      jec_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = jec_pkg::ST_MUL;
        end
      end
      jec_pkg::ST_MUL: begin
        prod_nxt  = {20'd0, diff} * {16'd0, cfg.deadzone_gain};
        dead_nxt  = mag < dz16;
        state_nxt = jec_pkg::ST_APPLY;
      end
      jec_pkg::ST_APPLY: begin
        unique case (cmd_r.kind)
          jec_pkg::CMD_TICK: begin
            tick_nxt = tick_r + 48'd1;
            if (tsc_r != '1) begin
              tsc_nxt = tsc_r + 32'd1;
            end
            if (tsr_r != '1) begin
              tsr_nxt = tsr_r + 32'd1;
            end
          end
          jec_pkg::CMD_AXIS: begin
            if (cmd_r.idx_ok) begin
              axis_store_nxt[cmd_r.idx[jec_pkg::AXIS_IDX_W-1:0]] = axis_val;
            end
          end
          jec_pkg::CMD_BUTTON: begin
            if (cmd_r.idx_ok) begin
              if (cfg.sticky_mode) begin
                if (btn_v == 17'sd1) begin
                  btn_store_nxt[cmd_r.idx[jec_pkg::BTN_IDX_W-1:0]] =
                    !btn_store_r[cmd_r.idx[jec_pkg::BTN_IDX_W-1:0]];
                end
              end else begin
                btn_store_nxt[cmd_r.idx[jec_pkg::BTN_IDX_W-1:0]] = btn_v != '0;
              end
            end
          end
          default: begin
          end
        endcase
        if (cmd_r.mark) begin
          dirty_nxt = 1'b1;
          tsc_nxt   = '0;
        end
        state_nxt = jec_pkg::ST_DECIDE;
      end
      jec_pkg::ST_DECIDE: begin
        if (report) begin
          dirty_nxt = 1'b0;
          tsr_nxt   = '0;
          walk_nxt  = '0;
          state_nxt = jec_pkg::ST_REPORT;
        end else begin
          state_nxt = jec_pkg::ST_IDLE;
        end
      end
      jec_pkg::ST_REPORT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = tick_r;
          out_last_nxt  = walk_r == EW'(jec_pkg::NUM_ENTRIES - 1);
          if (walk_r < EW'(NA)) begin
            out_kind_nxt = 1'b0;
            out_num_nxt  = 4'(walk_r);
            out_val_nxt  = axis_store_r[walk_r[jec_pkg::AXIS_IDX_W-1:0]];
          end else begin
            out_kind_nxt = 1'b1;
            out_num_nxt  = 4'(btn_walk);
            out_val_nxt  = {15'd0, btn_store_r[btn_walk[jec_pkg::BTN_IDX_W-1:0]]};
          end
          if (walk_r == EW'(jec_pkg::NUM_ENTRIES - 1)) begin
            state_nxt = jec_pkg::ST_IDLE;
          end else begin
            walk_nxt = walk_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = jec_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jec_pkg::ST_IDLE;
      walk_r      <= '0;
      dirty_r     <= 1'b0;
      tsc_r       <= '0;
      tsr_r       <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NA; i++) begin
        axis_store_r[i] <= '0;
      end
      for (int i = 0; i < NB; i++) begin
        btn_store_r[i] <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      walk_r       <= walk_nxt;
      dirty_r      <= dirty_nxt;
      tsc_r        <= tsc_nxt;
      tsr_r        <= tsr_nxt;
      tick_r       <= tick_nxt;
      out_valid_r  <= out_valid_nxt;
      axis_store_r <= axis_store_nxt;
      btn_store_r  <= btn_store_nxt;
    end
    cmd_r      <= cmd_nxt;
    prod_r     <= prod_nxt;
    dead_r     <= dead_nxt;
    out_kind_r <= out_kind_nxt;
    out_num_r  <= out_num_nxt;
    out_val_r  <= out_val_nxt;
    out_time_r <= out_time_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_channel_kind   = out_kind_r;
  assign out_channel_number = out_num_r;
  assign out_channel_value  = out_val_r;
  assign out_report_time    = out_time_r;
  assign out_last_entry     = out_last_r;

endmodule

// File: hw/rtl/joystick_event_conditioner.sv
// An accepted transaction passes through the front's holding register and a queue entry before
// the back end pops it into its command register. The back end handles one command at a time,
// stepping through pop, deadzone multiply, store update and report decision; when the command
// triggers a report it then walks all 24 entries out, waiting while out_ready holds an entry back.
// Reset (rst_n, synchronous, active low) clears stores, counters, queue and handshakes at once
// and loads configuration defaults; no clearing pass follows.
//
// Top level of the joystick event conditioner. Depends on jec_pkg, jec_front, jec_queue and
// jec_back.
module joystick_event_conditioner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic                in_event_kind,
  input  logic                in_init_flag,
  input  logic [7:0]          in_channel_index,
  input  logic signed [15:0]  in_sample_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_channel_kind,
  output logic [3:0]          out_channel_number,
  output logic signed [15:0]  out_channel_value,
  output logic [47:0]         out_report_time,
  output logic                out_last_entry,
  input  logic                cfg_we,
  input  logic [jec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jec_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers. Write them only while the block is idle; the block does not
  // enforce this itself, and the back end reads them directly without any shadowing.
  jec_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (jec_pkg::cfg_reg_t'(cfg_index))
        jec_pkg::REG_DEADZONE_LEVEL:     cfg_nxt.deadzone_level     = cfg_wdata[14:0];
        jec_pkg::REG_DEADZONE_GAIN:      cfg_nxt.deadzone_gain      = cfg_wdata[19:0];
        jec_pkg::REG_AXIS_REVERSE_MASK:  cfg_nxt.axis_reverse_mask  = cfg_wdata[7:0];
        jec_pkg::REG_BUTTON_INVERT_MASK: cfg_nxt.button_invert_mask = cfg_wdata[15:0];
        jec_pkg::REG_STICKY_MODE:        cfg_nxt.sticky_mode        = cfg_wdata[0];
        jec_pkg::REG_PUBLISH_INTERVAL:   cfg_nxt.publish_interval   = cfg_wdata;
        jec_pkg::REG_COALESCE_WINDOW:    cfg_nxt.coalesce_window    = cfg_wdata;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= jec_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front classifies each transaction into a tick, axis or button command
  // and parks it in a holding register until the queue has room.
  jec_pkg::q_stat_t q_stat;
  jec_pkg::cmd_t    push_cmd;
  jec_pkg::cmd_t    pop_cmd;
  logic             q_push;
  logic             q_pop;

  jec_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_event_kind    (in_event_kind),
    .in_init_flag     (in_init_flag),
    .in_channel_index (in_channel_index),
    .in_sample_value  (in_sample_value),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  // The queue lets the front keep taking transactions while the back end is
  // busy walking a report out.
  jec_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (push_cmd),
    .pop     (q_pop),
    .cmd_out (pop_cmd),
    .stat    (q_stat)
  );

  // The back end owns the channel store and tick counters. Each command is
  // applied, then the report condition is checked against the updated state;
  // a report streams every axis, then every button, through the output register.
  jec_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_stat             (q_stat),
    .q_cmd              (pop_cmd),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel_kind   (out_channel_kind),
    .out_channel_number (out_channel_number),
    .out_channel_value  (out_channel_value),
    .out_report_time    (out_report_time),
    .out_last_entry     (out_last_entry)
  );

`ifndef SYNTHESIS
  // The front never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  // The back end never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  // The final entry of a report is always the highest button.
  a_last_is_button: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_entry) |->
      (out_channel_kind && (out_channel_number == 4'(jec_pkg::NUM_BUTTONS - 1))))
    else $error("last report entry is not the final button");
`endif

endmodule
